// ===== design/bcc_pkg.sv =====
package bcc_pkg;

  localparam int unsigned ButtonCount = 4;
  localparam int unsigned TimeW       = 48;
  localparam int unsigned MsW         = 16;
  // threshold held in microseconds: ms * 1000 needs 26 bits
  localparam int unsigned ThrW        = MsW + 10;
  localparam int unsigned UsPerMs     = 1000;
  localparam int unsigned KindW       = 3;
  localparam int unsigned BtnW        = 2;
  localparam int unsigned CfgIdxW     = 2;

  localparam logic [CfgIdxW-1:0] CfgLongPressMs   = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] CfgDoubleClickMs = CfgIdxW'(1);

  localparam logic [MsW-1:0] LongPressMsReset   = MsW'(1000);
  localparam logic [MsW-1:0] DoubleClickMsReset = MsW'(300);

  typedef enum logic [KindW-1:0] {
    EvNone        = 3'd0,
    EvSingle      = 3'd1,
    EvDouble      = 3'd2,
    EvLongStart   = 3'd3,
    EvLongRelease = 3'd4,
    EvPairLong    = 3'd5
  } event_e;

  typedef struct packed {
    logic [ButtonCount-1:0] levels;
    logic [TimeW-1:0]       time_us;
  } in_item_t;

  typedef struct packed {
    event_e          event_kind;
    logic [BtnW-1:0] event_button;
  } out_item_t;

  typedef struct packed {
    logic             held;
    logic             long_fired;
    logic [TimeW-1:0] press_stamp;
    logic [TimeW-1:0] click_stamp;
  } btn_state_t;

  typedef struct packed {
    logic   hit;
    event_e kind;
    logic   pair_ge;
  } lane_res_t;

  function automatic logic [ThrW-1:0] ms_to_us(input logic [MsW-1:0] ms);
    logic [ThrW-1:0] prod;
    begin
      prod = ThrW'(ms) * ThrW'(UsPerMs);
      return prod;
    end
  endfunction

endpackage

// ===== design/bcc_lane.sv =====
module bcc_lane
  import bcc_pkg::*;
(
  input  logic                    pressed_i,
  input  logic [TimeW-1:0]        now_i,
  input  btn_state_t              state_i,
  input  logic [ThrW-1:0]         long_thr_i,
  input  logic [ThrW-1:0]         dbl_thr_i,
  output btn_state_t              state_o,
  output lane_res_t               res_o
);

  logic [TimeW-1:0] press_diff;
  logic [TimeW-1:0] click_diff;
  logic             long_ge;
  logic             dbl_lt;
  logic             click_pend;

  // floor(d / 1000) >= t  is the same as  d >= t * 1000
  assign press_diff = now_i - state_i.press_stamp;
  assign click_diff = now_i - state_i.click_stamp;
  assign long_ge    = press_diff >= TimeW'(long_thr_i);
  assign dbl_lt     = click_diff < TimeW'(dbl_thr_i);
  assign click_pend = state_i.click_stamp != '0;

  always_comb begin
    state_o       = state_i;
    res_o.hit     = 1'b0;
    res_o.kind    = EvNone;
    res_o.pair_ge = long_ge;
    if (pressed_i) begin
      if (!state_i.held) begin
        state_o.held        = 1'b1;
        state_o.press_stamp = now_i;
        state_o.long_fired  = 1'b0;
        // fresh press: elapsed is zero
        res_o.pair_ge       = long_thr_i == '0;
      end else if (!state_i.long_fired && long_ge) begin
        state_o.long_fired = 1'b1;
        res_o.hit          = 1'b1;
        res_o.kind         = EvLongStart;
      end
    end else if (state_i.held) begin
      state_o.held = 1'b0;
      if (state_i.long_fired) begin
        res_o.hit  = 1'b1;
        res_o.kind = EvLongRelease;
      end else if (click_pend && dbl_lt) begin
        state_o.click_stamp = '0;
        res_o.hit           = 1'b1;
        res_o.kind          = EvDouble;
      end else begin
        state_o.click_stamp = now_i;
      end
    end else if (click_pend && !dbl_lt) begin
      state_o.click_stamp = '0;
      res_o.hit           = 1'b1;
      res_o.kind          = EvSingle;
    end
  end

endmodule

// ===== design/bcc_merge.sv =====
module bcc_merge
  import bcc_pkg::*;
(
  input  btn_state_t [ButtonCount-1:0] cur_i,
  input  btn_state_t [ButtonCount-1:0] lane_state_i,
  input  lane_res_t  [ButtonCount-1:0] lane_res_i,
  output btn_state_t [ButtonCount-1:0] state_o,
  output out_item_t                    item_o
);

  logic found;

  always_comb begin
    found               = 1'b0;
    state_o             = cur_i;
    item_o.event_kind   = EvNone;
    item_o.event_button = '0;
    // lanes up to and including the first hit commit, later ones stay put
    for (int i = 0; i < ButtonCount; i++) begin
      if (!found) begin
        state_o[i] = lane_state_i[i];
        if (lane_res_i[i].hit) begin
          found               = 1'b1;
          item_o.event_kind   = lane_res_i[i].kind;
          item_o.event_button = BtnW'(i);
        end
      end
    end
    if (!found) begin
      if (state_o[0].held && state_o[1].held) begin
        if (lane_res_i[0].pair_ge && lane_res_i[1].pair_ge &&
            !state_o[0].long_fired && !state_o[1].long_fired) begin
          state_o[0].long_fired = 1'b1;
          state_o[1].long_fired = 1'b1;
          item_o.event_kind     = EvPairLong;
        end
      end else if (state_o[0].long_fired && state_o[1].long_fired) begin
        state_o[0].long_fired = 1'b0;
        state_o[1].long_fired = 1'b0;
      end
    end
  end

endmodule

// ===== design/button_click_classifier.sv =====
// Button click classifier: turns polled button levels into click events.
// Input channel: in_item_i (levels, active low, and a microsecond timestamp)
// with in_valid_i / in_stall_o. Output channel: out_item_o (event kind and
// button) with out_valid_o / out_stall_i. Every accepted item gives exactly
// one result, event kind none when nothing happened.
// The result of an accepted item is registered. One item per cycle is
// sustained while out_stall_i is low; all buttons are judged by per-button
// lanes in the same cycle and a priority stage picks the first event, so
// the rate is set by one 48-bit subtract and compare per lane.
// Thresholds are written through cfg_we_i / cfg_index_i / cfg_data_i in
// milliseconds (index 0 long press, index 1 double-click window) and are
// kept internally in microseconds; other indexes are ignored.
// Reset clears all button history, empties the output stages and loads
// 1000 ms and 300 ms. When the receiver stalls, the held result stays on the
// port and one more item is taken into a skid register; in_stall_o rises
// only once that register is full.
module button_click_classifier
  import bcc_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [MsW-1:0]     cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  in_item_t           in_item_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output out_item_t          out_item_o
);

  logic [ThrW-1:0] long_thr_q, long_thr_d;
  logic [ThrW-1:0] dbl_thr_q, dbl_thr_d;

  btn_state_t [ButtonCount-1:0] state_q, state_d;
  btn_state_t [ButtonCount-1:0] lane_state;
  lane_res_t  [ButtonCount-1:0] lane_res;
  btn_state_t [ButtonCount-1:0] merged_state;
  out_item_t                    new_item;

  out_item_t out_q, out_d;
  out_item_t skid_q, skid_d;
  logic      out_valid_q, out_valid_d;
  logic      skid_valid_q, skid_valid_d;

  logic in_accept;
  logic out_free;

  assign in_stall_o = skid_valid_q;
  assign in_accept  = in_valid_i && !skid_valid_q;
  assign out_free   = !out_valid_q || !out_stall_i;

  always_comb begin
    long_thr_d = long_thr_q;
    dbl_thr_d  = dbl_thr_q;
    if (cfg_we_i) begin
      if (cfg_index_i == CfgLongPressMs) begin
        long_thr_d = ms_to_us(cfg_data_i);
      end else if (cfg_index_i == CfgDoubleClickMs) begin
        dbl_thr_d = ms_to_us(cfg_data_i);
      end
    end
  end

  for (genvar g = 0; g < ButtonCount; g++) begin : g_lane
    bcc_lane u_lane (
      .pressed_i  (!in_item_i.levels[g]),
      .now_i      (in_item_i.time_us),
      .state_i    (state_q[g]),
      .long_thr_i (long_thr_q),
      .dbl_thr_i  (dbl_thr_q),
      .state_o    (lane_state[g]),
      .res_o      (lane_res[g])
    );
  end

  bcc_merge u_merge (
    .cur_i        (state_q),
    .lane_state_i (lane_state),
    .lane_res_i   (lane_res),
    .state_o      (merged_state),
    .item_o       (new_item)
  );

  assign state_d = in_accept ? merged_state : state_q;

  always_comb begin
    out_d        = out_q;
    skid_d       = skid_q;
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    if (out_free) begin
      if (skid_valid_q) begin
        out_d        = skid_q;
        out_valid_d  = 1'b1;
        skid_valid_d = 1'b0;
      end else if (in_accept) begin
        out_d       = new_item;
        out_valid_d = 1'b1;
      end else begin
        out_valid_d = 1'b0;
      end
    end else if (in_accept) begin
      skid_d       = new_item;
      skid_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      long_thr_q   <= ms_to_us(LongPressMsReset);
      dbl_thr_q    <= ms_to_us(DoubleClickMsReset);
      state_q      <= '0;
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      long_thr_q   <= long_thr_d;
      dbl_thr_q    <= dbl_thr_d;
      state_q      <= state_d;
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule
